// ===== hdl/wsp_pkg.sv =====
// Package for the weighted sample pool: default sizes, action and status codes.
// No dependencies.
package wsp_pkg;

  localparam int CAPACITY_DEF    = 1024;
  localparam int HANDLE_BITS_DEF = 16;
  localparam int WEIGHT_BITS_DEF = 32;

  localparam logic [1:0] ACT_APPEND        = 2'd0;
  localparam logic [1:0] ACT_TAKE_AT       = 2'd1;
  localparam logic [1:0] ACT_TAKE_UNIFORM  = 2'd2;
  localparam logic [1:0] ACT_TAKE_WEIGHTED = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

endpackage

// ===== hdl/wsp_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module wsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write when enabled; read data is registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/wsp_divider.sv =====
// Restoring divider that returns the remainder of a 32-bit word by the count.
// Depends on nothing; one quotient bit per cycle.
module wsp_divider #(
  parameter int CW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [CW-1:0] divisor,
  output logic          done,
  output logic [CW-1:0] remainder
);

  logic [31:0]   shreg;
  logic [CW:0]   rem;
  logic [5:0]    steps;
  logic          busy;
  logic [CW:0]   trial;

  assign trial = {rem[CW-1:0], shreg[31]};

  // Shift one dividend bit in per cycle and subtract when it fits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        shreg <= dividend;
        rem   <= '0;
        steps <= 6'd0;
      end else if (busy) begin
        shreg <= {shreg[30:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem <= trial - {1'b0, divisor};
        end else begin
          rem <= trial;
        end
        steps <= steps + 6'd1;
        if (steps == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem[CW-1:0];

endmodule

// ===== hdl/weighted_sample_pool.sv =====
// Weighted sample pool: handles with weights held in two RAMs.
// Depends on wsp_pkg, wsp_ram and wsp_divider.
//
// Usage: one item on the input channel (valid/stall) gives exactly one
// result item on the output channel. The block works on one item at a time
// and raises in_stall from acceptance until the result has been taken.
// Append and any failing action go straight to the output state after
// acceptance; a successful take at index reads the picked slot, reads the
// last slot and writes it back into the picked slot. Uniform take first
// computes the remainder of the random word by the count, one bit a cycle.
// Weighted take scans the weight RAM one entry a cycle through its single
// read port until the running sum reaches the threshold; the threshold
// multiply is split into two 32x32 products that are then added.
// The result is held in an output register; while out_stall is high the
// result stays unchanged and no new item is taken. After a result is taken
// the block is ready for the next item in the next cycle.
// Reset (rst, synchronous) empties the pool: count and total go to zero.
// The RAM contents are not cleared; only slots below the count are used.
module weighted_sample_pool
  import wsp_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [15:0] item_handle,
  input  logic [31:0] item_weight,
  input  logic [9:0]  slot_index,
  input  logic [31:0] random_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] taken_handle,
  output logic [31:0] taken_weight,
  output logic [10:0] entry_count,
  output logic [41:0] total_weight
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = 64;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_RDPK  = 4'd4;
  localparam logic [3:0] S_WAITP = 4'd5;
  localparam logic [3:0] S_RDLS  = 4'd6;
  localparam logic [3:0] S_WAITL = 4'd7;
  localparam logic [3:0] S_WRIT  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_SCANW = 4'd10;

  logic [3:0]             state;
  logic [CW-1:0]          count;
  logic [SW-1:0]          weight_sum;
  logic [31:0]            rnd;
  logic [AW-1:0]          pick;
  logic [AW-1:0]          scan_addr;
  logic [CW-1:0]          scan_issued;
  logic                   scan_live;
  logic [SW-1:0]          run;
  logic [SW-1:0]          limit;
  logic [SW-1:0]          prod_hi;
  logic [SW-1:0]          prod_lo;
  logic                   mul_phase;
  logic [HANDLE_BITS-1:0] hold_h;
  logic [WEIGHT_BITS-1:0] hold_w;

  // RAM ports.
  logic                   ram_we;
  logic [AW-1:0]          ram_addr;
  logic [HANDLE_BITS-1:0] h_wdata;
  logic [HANDLE_BITS-1:0] h_rdata;
  logic [WEIGHT_BITS-1:0] w_wdata;
  logic [WEIGHT_BITS-1:0] w_rdata;

  logic                   div_start;
  logic                   div_done;
  logic [CW-1:0]          div_rem;

  logic [AW-1:0]          last_addr;
  logic                   accept;

  wsp_ram #(.WIDTH(HANDLE_BITS), .DEPTH(CAPACITY)) u_handle_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(h_wdata), .rdata(h_rdata)
  );

  wsp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(CAPACITY)) u_weight_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(w_wdata), .rdata(w_rdata)
  );

  wsp_divider #(.CW(CW)) u_divider (
    .clk(clk), .rst(rst), .start(div_start), .dividend(random_word), .divisor(count),
    .done(div_done), .remainder(div_rem)
  );

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign last_addr = AW'(count - CW'(1));
  assign div_start = accept && (action == ACT_TAKE_UNIFORM) && (count != '0);

  // RAM address and write data come from the sequencer state.
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = pick;
    h_wdata  = HANDLE_BITS'(item_handle);
    w_wdata  = WEIGHT_BITS'(item_weight);
    case (state)
      S_IDLE: begin
        ram_addr = AW'(count);
        ram_we   = accept && (action == ACT_APPEND) && (count < CW'(CAPACITY));
      end
      S_SCAN:  ram_addr = scan_addr;
      S_RDLS:  ram_addr = last_addr;
      S_WAITL: ram_addr = last_addr;
      S_WRIT: begin
        ram_we   = 1'b1;
        ram_addr = pick;
        h_wdata  = h_rdata;
        w_wdata  = w_rdata;
      end
      default: ram_addr = pick;
    endcase
  end

  // Sequencer for all four actions.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      weight_sum <= '0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            rnd          <= random_word;
            pick         <= AW'(slot_index);
            taken_handle <= '0;
            taken_weight <= '0;
            status       <= ST_OK;
            state        <= S_OUT;
            if (action == ACT_APPEND) begin
              if (count >= CW'(CAPACITY)) begin
                status <= ST_FULL;
              end else begin
                count      <= count + CW'(1);
                weight_sum <= weight_sum + SW'(WEIGHT_BITS'(item_weight));
              end
            end else if (count == '0) begin
              status <= ST_EMPTY;
            end else if (action == ACT_TAKE_AT) begin
              if ({6'd0, slot_index} >= 16'(count)) begin
                status <= ST_RANGE;
              end else begin
                state <= S_RDPK;
              end
            end else if (action == ACT_TAKE_UNIFORM) begin
              state <= S_DIV;
            end else begin
              mul_phase <= 1'b0;
              state     <= S_MUL;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            pick  <= AW'(div_rem);
            state <= S_RDPK;
          end
        end
        S_MUL: begin
          // Two 32x32 products, then add with the low one shifted down.
          if (!mul_phase) begin
            prod_hi   <= SW'(weight_sum[63:32]) * SW'(rnd);
            prod_lo   <= SW'(weight_sum[31:0]) * SW'(rnd);
            mul_phase <= 1'b1;
          end else begin
            limit       <= prod_hi + (prod_lo >> 32);
            run         <= '0;
            scan_addr   <= '0;
            scan_issued <= '0;
            scan_live   <= 1'b0;
            state       <= S_SCAN;
          end
        end
        S_SCAN: begin
          // One read issued per cycle; read data of the previous address is checked.
          if (scan_live && (limit <= run + SW'(w_rdata))) begin
            pick  <= scan_addr - AW'(1);
            state <= S_RDPK;
          end else if (scan_issued == count) begin
            state <= S_SCANW;
          end else begin
            if (scan_live) begin
              run <= run + SW'(w_rdata);
            end
            scan_addr   <= scan_addr + AW'(1);
            scan_issued <= scan_issued + CW'(1);
            scan_live   <= 1'b1;
          end
        end
        S_SCANW: begin
          pick  <= last_addr;
          state <= S_RDPK;
        end
        S_RDPK: state <= S_WAITP;
        S_WAITP: begin
          hold_h <= h_rdata;
          hold_w <= w_rdata;
          state  <= S_RDLS;
        end
        S_RDLS: state <= S_WAITL;
        S_WAITL: state <= S_WRIT;
        S_WRIT: begin
          taken_handle <= 16'(hold_h);
          taken_weight <= 32'(hold_w);
          count        <= count - CW'(1);
          weight_sum   <= weight_sum - SW'(hold_w);
          state        <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign entry_count  = 11'(count);
  assign total_weight = weight_sum[41:0];

endmodule
